// ===== sv/pst_pkg.sv =====
`timescale 1ns / 1ps
// Package for the peer sync table: field widths, register codes and defaults.
// No dependencies; used by peer_sync_table_lru_top and its bench.
package pst_pkg;

  // Table geometry defaults
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned KEY_BYTES_DEF   = 8;

  // Fixed field widths
  localparam int unsigned KEY_IN_W  = 64;
  localparam int unsigned VER_W     = 8;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned OCC_W     = 5;

  // Stream packing
  localparam int unsigned IN_FIELDS_W  = KEY_IN_W + VER_W + 1 + STAMP_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 1 + 1 + SLOT_W + OCC_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUCCESS_BACKOFF = 2'd0,
    CFG_FAILED_BACKOFF  = 2'd1
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] SUCCESS_BACKOFF_RST = 32'd60000;
  localparam logic [CFG_W-1:0] FAILED_BACKOFF_RST  = 32'd5000;

  typedef enum logic {
    REQ_DECIDE = 1'b0,
    REQ_RECORD = 1'b1
  } req_e;

endpackage

// ===== sv/pst_ram.sv =====
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM holding table entries.
// Read data is registered. No package dependency.
module pst_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 105
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/peer_sync_table_lru_top.sv =====
`timescale 1ns / 1ps
// Peer sync table with LRU replacement: top level, scan sequencer and output stage.
// Depends on pst_pkg and pst_ram.
//
//  Channel   | Direction | Handshake            | Payload
//  ----------+-----------+----------------------+-----------------------------------------
//  s_axis    | in        | tvalid / tready      | tuser: req_type; tdata: key, version, ...
//  m_axis    | out       | tvalid / tready      | tdata: connect, hit, slot, occupancy
//  cfg       | in        | cfg_we_i (no wait)   | cfg_idx_i selects register, cfg_wdata_i
//
// Each item runs through the scan, a drain, an evaluate/write-back and a result state
// before its result is loaded, and the next item is taken once the block is back in
// idle. The scan reads one entry per cycle from the single read port of the entry RAM.
// Reset clears the valid bits and the occupancy count and loads the backoff registers
// with their reset values at once; entry contents need no clearing pass. The input is taken
// only between items; a result waiting in the output register does not block acceptance,
// but the next result holds in the result state until the output register frees up.
module peer_sync_table_lru_top
  import pst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BYTES   = KEY_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [63:0] peer_key, [71:64] version, [72] sync_ok, [104:73] now_ms, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] req_type
  input  logic                   s_axis_tuser_i,
  // master side
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] connect, [1] hit, [5:2] slot, [10:6] occupancy, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_W = 8 * KEY_BYTES;
  localparam int unsigned ENT_W = KEY_W + VER_W + 1 + STAMP_W;
  localparam int unsigned PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_RESP
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [CFG_W-1:0] succ_bo_q, fail_bo_q;

  // Request fields, held for the whole item
  logic             req_q;
  logic [KEY_W-1:0] key_q;
  logic [VER_W-1:0] ver_q;
  logic             ok_q;
  logic [STAMP_W-1:0] now_q;

  // Table control state
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CNT_W-1:0]       cnt_q;

  // Scan pipeline
  logic [IDX_W-1:0] addr_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_vld_q;

  // Scan results
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [VER_W-1:0]   m_ver_q;
  logic               m_ok_q;
  logic [STAMP_W-1:0] m_stamp_q;
  logic               empty_fnd_q;
  logic [IDX_W-1:0]   empty_idx_q;
  logic [STAMP_W-1:0] best_stamp_q;
  logic [IDX_W-1:0]   best_idx_q;

  // Evaluation results
  logic [STAMP_W-1:0] age_q;
  logic [CFG_W-1:0]   bo_q;
  logic               ver_ne_q;
  logic [IDX_W-1:0]   slot_q;

  // Output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // RAM interface
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  // Entry fields as read back from the RAM
  logic [KEY_W-1:0]   ent_key;
  logic [VER_W-1:0]   ent_ver;
  logic               ent_ok;
  logic [STAMP_W-1:0] ent_stamp;
  logic               ent_vld;

  logic             in_acc;
  logic             scan_last;
  logic [IDX_W-1:0] wr_idx;
  logic             resp_load;
  logic             connect;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_last       = (addr_q == IDX_W'(TABLE_DEPTH - 1));

  assign {ent_stamp, ent_ok, ent_ver, ent_key} = ram_rdata;
  assign ent_vld = valid_q[cmp_idx_q];

  // Matching entry first, else lowest empty slot, else the oldest stamp
  assign wr_idx = hit_q ? hit_idx_q : (empty_fnd_q ? empty_idx_q : best_idx_q);

  // Write back only after the scan has finished, so a read never meets a pending write
  assign ram_we    = (state_q == ST_EVAL) && (req_q == REQ_RECORD);
  assign ram_waddr = wr_idx;
  assign ram_wdata = {now_q, ok_q, ver_q, key_q};
  assign ram_raddr = addr_q;

  assign resp_load = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready_i);
  assign connect   = (req_q == REQ_DECIDE) && (!hit_q || ver_ne_q || (age_q >= bo_q));

  pst_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      succ_bo_q <= SUCCESS_BACKOFF_RST;
      fail_bo_q <= FAILED_BACKOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SUCCESS_BACKOFF: succ_bo_q <= cfg_wdata_i;
        CFG_FAILED_BACKOFF:  fail_bo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer: state, table control and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      cnt_q     <= '0;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      // a read issued during the scan is compared once its registered data returns
      cmp_vld_q <= (state_q == ST_SCAN);
      if (resp_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          addr_q <= '0;
          if (in_acc) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue one read per cycle
          if (scan_last) begin
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (req_q == REQ_RECORD) begin
            valid_q[wr_idx] <= 1'b1;
            // an eviction reuses a valid slot and leaves the count alone
            if (!hit_q && empty_fnd_q) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (resp_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q        <= s_axis_tuser_i;
      key_q        <= s_axis_tdata_i[KEY_W-1:0];
      ver_q        <= s_axis_tdata_i[KEY_IN_W +: VER_W];
      ok_q         <= s_axis_tdata_i[KEY_IN_W + VER_W];
      now_q        <= s_axis_tdata_i[KEY_IN_W + VER_W + 1 +: STAMP_W];
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      empty_fnd_q  <= 1'b0;
      empty_idx_q  <= '0;
      best_stamp_q <= '1;
      best_idx_q   <= '0;
    end
    if (state_q == ST_SCAN) begin
      cmp_idx_q <= addr_q;
    end
    if (cmp_vld_q) begin
      // first valid match wins
      if (ent_vld && (ent_key == key_q) && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
        m_ver_q   <= ent_ver;
        m_ok_q    <= ent_ok;
        m_stamp_q <= ent_stamp;
      end
      if (!ent_vld && !empty_fnd_q) begin
        empty_fnd_q <= 1'b1;
        empty_idx_q <= cmp_idx_q;
      end
      // strict compare keeps the lowest index on ties
      if (ent_vld && (ent_stamp < best_stamp_q)) begin
        best_stamp_q <= ent_stamp;
        best_idx_q   <= cmp_idx_q;
      end
    end
    if (state_q == ST_EVAL) begin
      age_q    <= now_q - m_stamp_q;
      bo_q     <= m_ok_q ? succ_bo_q : fail_bo_q;
      ver_ne_q <= (m_ver_q != ver_q);
      if (req_q == REQ_RECORD) begin
        slot_q <= wr_idx;
      end else begin
        slot_q <= hit_q ? hit_idx_q : '0;
      end
    end
    if (resp_load) begin
      m_data_q <= {{PAD_W{1'b0}}, OCC_W'(cnt_q), SLOT_W'(slot_q), hit_q, connect};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // The fill count tracks the valid bits exactly
  a_cnt_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(cnt_q))
    else $error("occupancy count out of step with valid bits");

  // Occupancy grows by at most one per cycle and never shrinks
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1))
    else $error("occupancy moved by more than one");

  // Compare data only arrives during the scan or the drain that follows it
  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
    else $error("compare data outside scan");

  // A record always leaves its slot valid
  a_record_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(wr_idx)])
    else $error("record left its slot invalid");

  // A record never answers connect
  a_record_no_connect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resp_load && (req_q == REQ_RECORD)) |=> !m_axis_tdata_o[0])
    else $error("record answered connect");

endmodule

// ===== bench/peer_sync_table_lru_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for peer_sync_table_lru_top: a directed stimulus table, then random
// phases under several backoff settings, checked against typed values or an in-bench predictor.
// Depends on pst_pkg and the block's RTL only.
module peer_sync_table_lru_top_tb;
  import pst_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  // Acceptance to loaded result: the scan plus the drain, evaluate and result states
  localparam int unsigned ITEM_LATENCY = DEPTH + 3;
  localparam int unsigned PAD_W        = IN_TDATA_W - IN_FIELDS_W;
  // Only the low KEY_BYTES bytes of a key take part; a shift by 64 yields zero, so this
  // also gives all ones at eight bytes
  localparam logic [KEY_IN_W-1:0] KEY_MASK = (64'd1 << (8 * KEY_BYTES_DEF)) - 64'd1;
  // Index that selects no register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int unsigned KEY_POOL_N = 24;
  localparam int unsigned N_PHASES   = 5;

  typedef struct packed {
    req_e                req;
    logic [KEY_IN_W-1:0] key;
    logic [VER_W-1:0]    ver;
    logic                ok;
    logic [STAMP_W-1:0]  now;
  } peer_req_t;

  typedef struct packed {
    logic              connect;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [OCC_W-1:0]  occ;
  } sync_result_t;

  typedef struct {
    peer_req_t    rq;
    bit           typed;
    sync_result_t want;
  } stim_row_t;

  // Clock, reset and all block inputs start at known values
  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tready  = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  wire                    s_tready;
  wire                    m_tvalid;
  wire  [OUT_TDATA_W-1:0] m_tdata;

  // Predictor copy of the peer table and the backoff registers
  logic                tbl_valid [DEPTH];
  logic [KEY_IN_W-1:0] tbl_key   [DEPTH];
  logic [VER_W-1:0]    tbl_ver   [DEPTH];
  logic                tbl_ok    [DEPTH];
  logic [STAMP_W-1:0]  tbl_stamp [DEPTH];
  logic [CFG_W-1:0]    ok_backoff;
  logic [CFG_W-1:0]    fail_backoff;

  sync_result_t        pending_results[$];
  stim_row_t           directed_rows[$];
  logic [KEY_IN_W-1:0] key_pool[KEY_POOL_N];
  logic [STAMP_W-1:0]  clock_ms;

  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int sink_hold;
  int mismatch_count = 0;
  int decide_count   = 0;
  int record_count   = 0;
  int hit_count      = 0;
  int evict_count    = 0;

  peer_sync_table_lru_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Timeout: results still outstanding: %0d", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  // Look up the key, apply a record to the table, and return the result the block owes.
  function automatic sync_result_t predict_sync_result(peer_req_t rq);
    logic [KEY_IN_W-1:0] k;
    logic [STAMP_W-1:0]  age;
    logic [STAMP_W-1:0]  oldest;
    int                  found;
    int                  empty_slot;
    int                  pick;
    int                  occ;
    sync_result_t        r;
    k     = rq.key & KEY_MASK;
    found = -1;
    r     = '0;
    for (int i = 0; i < DEPTH; i++)
      if (found < 0 && tbl_valid[i] && tbl_key[i] == k) found = i;
    r.hit = (found >= 0);
    if (r.hit) hit_count++;
    if (rq.req == REQ_DECIDE) begin
      decide_count++;
      if (found < 0) begin
        // Unknown peer: always connect, slot reads zero
        r.connect = 1'b1;
      end else begin
        age       = rq.now - tbl_stamp[found];
        r.slot    = found[SLOT_W-1:0];
        r.connect = (tbl_ver[found] != rq.ver) ||
                    (age >= (tbl_ok[found] ? ok_backoff : fail_backoff));
      end
    end else begin
      record_count++;
      pick = found;
      if (pick < 0) begin
        // Claim the lowest empty slot; with none, evict the smallest raw stamp,
        // lowest index winning a tie
        empty_slot = -1;
        oldest     = '1;
        pick       = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (!tbl_valid[i]) begin
            if (empty_slot < 0) empty_slot = i;
          end else if (tbl_stamp[i] < oldest) begin
            oldest = tbl_stamp[i];
            pick   = i;
          end
        end
        if (empty_slot >= 0) pick = empty_slot;
        else evict_count++;
        tbl_valid[pick] = 1'b1;
        tbl_key[pick]   = k;
      end
      tbl_ver[pick]   = rq.ver;
      tbl_ok[pick]    = rq.ok;
      tbl_stamp[pick] = rq.now;
      r.slot          = pick[SLOT_W-1:0];
    end
    occ = 0;
    for (int i = 0; i < DEPTH; i++) occ += tbl_valid[i];
    r.occ = occ[OCC_W-1:0];
    return r;
  endfunction

  task automatic add_row(req_e req, logic [KEY_IN_W-1:0] key, logic [VER_W-1:0] ver,
                         logic ok, logic [STAMP_W-1:0] now, bit typed, logic c, logic h,
                         logic [SLOT_W-1:0] s, logic [OCC_W-1:0] o);
    stim_row_t row;
    row.rq.req       = req;
    row.rq.key       = key;
    row.rq.ver       = ver;
    row.rq.ok        = ok;
    row.rq.now       = now;
    row.typed        = typed;
    row.want.connect = c;
    row.want.hit     = h;
    row.want.slot    = s;
    row.want.occ     = o;
    directed_rows.push_back(row);
  endtask

  // Offer one item, hold it until taken, then queue what the block must answer.
  // Valid is only ever lowered before an item is offered, never while one waits.
  task automatic send_request(peer_req_t rq, bit typed, sync_result_t typed_want);
    int bursts;
    sync_result_t predicted;
    if (src_idle && $urandom_range(0, 2) == 0) begin
      // Chain a few short bursts so the gap can end anywhere in the block's scan
      s_tvalid <= 1'b0;
      bursts = $urandom_range(1, 6);
      repeat (bursts) repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq.req;
    s_tdata  <= {{PAD_W{1'b0}}, rq.now, rq.ok, rq.ver, rq.key};
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
    predicted = predict_sync_result(rq);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  // Stop offering and wait until every result is back and the block takes input again.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 || !s_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    case (idx)
      CFG_SUCCESS_BACKOFF: ok_backoff = value;
      CFG_FAILED_BACKOFF:  fail_backoff = value;
      default: ;
    endcase
  endtask

  // Mostly keys from a small pool, so the table fills and evicts often; half the decides
  // aim at a stored peer with a time right around its backoff edge.
  function automatic peer_req_t make_random_request();
    peer_req_t rq;
    int        live[$];
    int        pick;
    rq.req = $urandom_range(0, 1) ? REQ_RECORD : REQ_DECIDE;
    rq.ok  = $urandom_range(0, 1);
    case ($urandom_range(0, 19))
      0:       clock_ms = $urandom;
      1, 2:    ; // hold time still: equal stamps test the eviction tie rule
      default: clock_ms = clock_ms + $urandom_range(1, 4000);
    endcase
    rq.now = clock_ms;
    rq.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                         : key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    rq.ver = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2);
    if (rq.req == REQ_DECIDE && $urandom_range(0, 1)) begin
      for (int i = 0; i < DEPTH; i++)
        if (tbl_valid[i]) live.push_back(i);
      if (live.size() != 0) begin
        pick   = live[$urandom_range(0, live.size() - 1)];
        rq.key = tbl_key[pick];
        if ($urandom_range(0, 4) != 0) rq.ver = tbl_ver[pick];
        rq.now = tbl_stamp[pick] + (tbl_ok[pick] ? ok_backoff : fail_backoff)
                 + $urandom_range(0, 4) - 2;
      end
    end
    return rq;
  endfunction

  task automatic report_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Result sink: ready drops low in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (sink_idle && $urandom_range(0, 4) == 0) begin
      m_tready  <= 1'b0;
      sink_hold <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest outstanding expectation
  always @(posedge clk_i) begin
    sync_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got tdata 0x%0h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("connect", want.connect, m_tdata[0]);
        report_field("hit", want.hit, m_tdata[1]);
        report_field("slot", want.slot, m_tdata[5:2]);
        report_field("occupancy", want.occ, m_tdata[10:6]);
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] ph_ok [N_PHASES];
    logic [CFG_W-1:0] ph_fail [N_PHASES];
    int               ph_items [N_PHASES];
    sync_result_t     none;

    none         = '0;
    ok_backoff   = SUCCESS_BACKOFF_RST;
    fail_backoff = FAILED_BACKOFF_RST;
    clock_ms     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_ver[i]   = '0;
      tbl_ok[i]    = 1'b0;
      tbl_stamp[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};

    // Backoff settings per phase: both zero, both at the top, moderate, wide, and the
    // reset values again for a last stretch with no idling at all
    ph_ok[0] = '0;                         ph_fail[0] = '0;
    ph_ok[1] = '1;                         ph_fail[1] = '1;
    ph_ok[2] = $urandom_range(1, 100000);  ph_fail[2] = $urandom_range(1, 20000);
    ph_ok[3] = $urandom;                   ph_fail[3] = $urandom_range(0, 3000);
    ph_ok[4] = SUCCESS_BACKOFF_RST;        ph_fail[4] = FAILED_BACKOFF_RST;
    ph_items = '{210, 210, 210, 210, 110};

    // Directed table, run under the reset backoffs (60000 ok, 5000 failed).
    // Expected values are typed where they follow directly from the table state.
    add_row(REQ_DECIDE, '0, 8'd0, 1'b0, 32'd0, 1, 1'b1, 1'b0, 4'd0, 5'd0);   // empty table
    add_row(REQ_RECORD, '0, 8'd0, 1'b1, 32'd0, 1, 1'b0, 1'b0, 4'd0, 5'd1);
    add_row(REQ_DECIDE, '0, 8'd0, 1'b0, 32'd59999, 1, 1'b0, 1'b1, 4'd0, 5'd1); // one short
    add_row(REQ_DECIDE, '0, 8'd0, 1'b0, 32'd60000, 1, 1'b1, 1'b1, 4'd0, 5'd1); // at backoff
    add_row(REQ_DECIDE, '0, 8'd255, 1'b0, 32'd1, 1, 1'b1, 1'b1, 4'd0, 5'd1);   // new version
    add_row(REQ_RECORD, '1, 8'd255, 1'b0, '1, 1, 1'b0, 1'b0, 4'd1, 5'd2);
    // Age wraps past zero; sync_ok on a decide must not matter
    add_row(REQ_DECIDE, '1, 8'd255, 1'b1, 32'd4998, 1, 1'b0, 1'b1, 4'd1, 5'd2);
    add_row(REQ_DECIDE, '1, 8'd255, 1'b0, 32'd4999, 1, 1'b1, 1'b1, 4'd1, 5'd2);
    add_row(REQ_RECORD, '0, 8'd7, 1'b0, 32'd100, 1, 1'b0, 1'b1, 4'd0, 5'd2);    // update hit
    // Fill the rest of the table
    for (int i = 2; i < DEPTH; i++)
      add_row(REQ_RECORD, 64'h0123_4567_89ab_0000 + i, i, i % 2, 32'd1000 + i, 0,
              1'b0, 1'b0, 4'd0, 5'd0);
    // Full table: slot 0 has the smallest stamp and goes; its key then misses
    add_row(REQ_RECORD, 64'hdead_beef_0000_0001, 8'd1, 1'b1, 32'd200, 1,
            1'b0, 1'b0, 4'd0, 5'd16);
    add_row(REQ_DECIDE, '0, 8'd7, 1'b0, 32'd100, 1, 1'b1, 1'b0, 4'd0, 5'd16);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      send_request(directed_rows[r].rq, directed_rows[r].typed, directed_rows[r].want);
    drain_results();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // Block is idle here: reprogram both backoffs, and poke the unused index once
      write_reg(CFG_SUCCESS_BACKOFF, ph_ok[ph]);
      write_reg(CFG_FAILED_BACKOFF, ph_fail[ph]);
      if (ph == 0) write_reg(CFG_IDX_SPARE, $urandom);
      cfg_we <= 1'b0;
      for (int n = 0; n < ph_items[ph]; n++) begin
        // Re-pick idling every 40 items so quiet stretches appear; none in the last phase
        if (n % 40 == 0) begin
          src_idle  = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
          sink_idle = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        send_request(make_random_request(), 1'b0, none);
      end
      drain_results();
    end

    // Let any stray result show up before the verdict
    repeat (2 * ITEM_LATENCY) @(posedge clk_i);
    $display("Covered %0d decide and %0d record items: %0d hits, %0d evictions.",
             decide_count, record_count, hit_count, evict_count);
    $display("Backoffs: reset values plus %0d programmed settings, zero and all-ones included.",
             N_PHASES);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
